>>> design/pcam_pkg.sv
// shared types, constants and functions of the pci configuration access block
`default_nettype none
package pcam_pkg;
    localparam int SPACE_BYTES_DEF = 256;
    localparam int SHADOW_SEGMENTS_DEF = 16;
    localparam int NFUNCS = 3;
    localparam logic [31:0] ADDR_CLEAR_MASK = 32'h7F00_0003;
    localparam logic [15:0] IDE_BASE_RESET = 16'hC000;
    localparam logic [15:0] IDE_BASE_MASK = 16'hFFF0;

    localparam logic [1:0] SLOT_HOST = 2'd0;
    localparam logic [1:0] SLOT_ISA = 2'd1;
    localparam logic [1:0] SLOT_IDE = 2'd2;

    localparam logic [7:0] DEVFN_HOST = 8'h00;
    localparam logic [7:0] DEVFN_ISA = 8'h08;
    localparam logic [7:0] DEVFN_IDE = 8'h09;

    localparam logic FUNC_READ = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic       func;
        logic [2:0] port_offset;
        logic [7:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] shadow_write_enable;
        logic        remap_valid;
        logic [15:0] remap_base;
    } out_item_t;

    // request from the front end to the memory engine
    typedef struct packed {
        logic       is_write;
        logic [1:0] slot;
        logic [7:0] off;
        logic [7:0] data;
    } mem_req_t;

    // reset content of one byte
    function automatic logic [7:0] default_byte(input logic [1:0] slot, input logic [7:0] o);
        logic [7:0] v;
        v = 8'h00;
        case (slot)
            SLOT_HOST: begin
                case (o)
                    8'h00: v = 8'h86; 8'h01: v = 8'h80; 8'h02: v = 8'h37;
                    8'h03: v = 8'h12; 8'h04: v = 8'h06; 8'h06: v = 8'h80;
                    8'h07: v = 8'h02; 8'h08: v = 8'h02; 8'h0B: v = 8'h06;
                    8'h51: v = 8'h01; 8'h53: v = 8'h80; 8'h57: v = 8'h01;
                    8'h58: v = 8'h10; 8'h72: v = 8'h02;
                    default: v = 8'h00;
                endcase
            end
            SLOT_ISA: begin
                case (o)
                    8'h00: v = 8'h86; 8'h01: v = 8'h80; 8'h03: v = 8'h70;
                    8'h04: v = 8'h07; 8'h07: v = 8'h02; 8'h0A: v = 8'h01;
                    8'h0B: v = 8'h06; 8'h0E: v = 8'h80; 8'h4C: v = 8'h4D;
                    8'h4E: v = 8'h03; 8'h60: v = 8'h80; 8'h61: v = 8'h80;
                    8'h62: v = 8'h80; 8'h63: v = 8'h80; 8'h69: v = 8'h02;
                    8'h70: v = 8'h80; 8'h76: v = 8'h0C; 8'h77: v = 8'h0C;
                    8'h78: v = 8'h02; 8'hA0: v = 8'h08; 8'hA8: v = 8'h0F;
                    default: v = 8'h00;
                endcase
            end
            SLOT_IDE: begin
                case (o)
                    8'h00: v = 8'h86; 8'h01: v = 8'h80; 8'h02: v = 8'h10;
                    8'h03: v = 8'h70; 8'h04: v = 8'h01; 8'h06: v = 8'h80;
                    8'h07: v = 8'h02; 8'h09: v = 8'h80; 8'h0A: v = 8'h01;
                    8'h0B: v = 8'h01; 8'h20: v = 8'h01; 8'h21: v = 8'hC0;
                    8'h41: v = 8'h80; 8'h43: v = 8'h80;
                    default: v = 8'h00;
                endcase
            end
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] host_rule(input logic [7:0] o, input logic [7:0] old,
                                             input logic [7:0] d);
        logic [7:0] v;
        if (o <= 8'h03 || o == 8'h06 || (o >= 8'h08 && o <= 8'h0C) ||
            (o >= 8'h10 && o <= 8'h4F) || (o >= 8'h69 && o <= 8'h6F) ||
            (o >= 8'h73 && o <= 8'h8F) || o == 8'h92 || o >= 8'h94) begin
            v = old;
        end else begin
            case (o)
                8'h04: v = (d & 8'h40) | 8'h06;
                8'h05: v = d & 8'h01;
                8'h07: v = old & ~(d & 8'hF9);
                8'h0D: v = d & 8'hF8;
                8'h50: v = d & 8'h70;
                8'h51: v = (d & 8'h80) | 8'h01;
                default: v = d;
            endcase
        end
        return v;
    endfunction

    function automatic logic [7:0] isa_rule(input logic [7:0] o, input logic [7:0] old,
                                            input logic [7:0] d);
        logic [7:0] v;
        if (o <= 8'h03 || (o >= 8'h08 && o <= 8'h4B) || o == 8'h4D ||
            (o >= 8'h50 && o <= 8'h5F) || (o >= 8'h64 && o <= 8'h68) ||
            (o >= 8'h6C && o <= 8'h6F) || (o >= 8'h71 && o <= 8'h75) ||
            (o >= 8'h7A && o <= 8'h7F) || o == 8'h81 || (o >= 8'h83 && o <= 8'h9F) ||
            o == 8'hA1 || o == 8'hA9 || o == 8'hAD || o >= 8'hAF) begin
            v = old;
        end else if (o >= 8'h60 && o <= 8'h63) begin
            v = d & 8'h8F;
        end else begin
            case (o)
                8'h04: v = (d & 8'h08) | 8'h07;
                8'h05: v = d & 8'h01;
                8'h07: v = (old & ~(d & 8'h78)) | 8'h02;
                8'h4F: v = d & 8'h01;
                8'h6A: v = d & 8'hD7;
                8'h80: v = d & 8'h80;
                default: v = d;
            endcase
        end
        return v;
    endfunction

    function automatic logic [7:0] ide_rule(input logic [7:0] o, input logic [7:0] old,
                                            input logic [7:0] d);
        logic [7:0] v;
        if (o <= 8'h03 || (o >= 8'h08 && o <= 8'h0C) || (o >= 8'h0E && o <= 8'h1F) ||
            (o >= 8'h24 && o <= 8'h3F) || o >= 8'h45) begin
            v = old;
        end else if (o == 8'h20) begin
            v = d | 8'h01;
        end else begin
            v = d;
        end
        return v;
    endfunction
endpackage
`default_nettype wire

>>> design/pcam_store.sv
// configuration byte memory with reset clearing pass and read-modify-write engine
`default_nettype none
module pcam_store #(
    parameter int SPACE_BYTES = pcam_pkg::SPACE_BYTES_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  req_valid,
    input  pcam_pkg::mem_req_t   req,
    output logic                 busy,
    output logic                 done,
    output logic [7:0]           rdata,
    output logic                 base_valid,
    output logic [15:0]          base
);
    localparam int AW = $clog2(SPACE_BYTES);
    localparam int DEPTH = pcam_pkg::NFUNCS * SPACE_BYTES;
    localparam int IW = $clog2(DEPTH);

    typedef enum logic [4:0] {
        ST_INIT  = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_RMW   = 5'b00100,
        ST_B21   = 5'b01000,
        ST_B21W  = 5'b10000
    } st_t;

    logic [7:0] mem [DEPTH];
    st_t state_reg, state_next;
    logic [1:0] init_slot_reg;
    logic [AW-1:0] init_off_reg;
    pcam_pkg::mem_req_t req_reg;
    logic [7:0] q_reg;
    logic [7:0] lo_reg;
    logic [IW-1:0] raddr, waddr, req_addr;
    logic we;
    logic [7:0] wdata, mod;

    function automatic logic [IW-1:0] addr_of(input logic [1:0] s, input logic [7:0] o);
        return IW'(32'(s) * SPACE_BYTES + 32'(o[AW-1:0]));
    endfunction

    assign req_addr = addr_of(req_reg.slot, req_reg.off);

    always_comb begin
        case (req_reg.slot)
            pcam_pkg::SLOT_HOST: mod = pcam_pkg::host_rule(req_reg.off, q_reg, req_reg.data);
            pcam_pkg::SLOT_ISA:  mod = pcam_pkg::isa_rule(req_reg.off, q_reg, req_reg.data);
            default:             mod = pcam_pkg::ide_rule(req_reg.off, q_reg, req_reg.data);
        endcase
    end

    always_comb begin
        state_next = state_reg;
        we = 1'b0;
        waddr = req_addr;
        wdata = mod;
        raddr = addr_of(req.slot, req.off);
        done = 1'b0;
        base_valid = 1'b0;
        case (state_reg)
            ST_INIT: begin
                we = 1'b1;
                waddr = addr_of(init_slot_reg, 8'(init_off_reg));
                wdata = pcam_pkg::default_byte(init_slot_reg, 8'(init_off_reg));
                if (init_slot_reg == pcam_pkg::SLOT_IDE &&
                    init_off_reg == AW'(SPACE_BYTES - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (req_valid) state_next = ST_RMW;
            end
            ST_RMW: begin
                we = req_reg.is_write;
                if (req_reg.is_write && req_reg.slot == pcam_pkg::SLOT_IDE &&
                    req_reg.off == 8'h23 && SPACE_BYTES > 8'h23) begin
                    raddr = addr_of(pcam_pkg::SLOT_IDE, 8'h21);
                    state_next = ST_B21;
                end else begin
                    done = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_B21: begin
                raddr = addr_of(pcam_pkg::SLOT_IDE, 8'h20);
                state_next = ST_B21W;
            end
            ST_B21W: begin
                done = 1'b1;
                base_valid = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ide base: byte 0x21 read first, then 0x20
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        q_reg <= mem[raddr];
        if (state_reg == ST_B21) lo_reg <= q_reg;
        if (state_reg == ST_IDLE && req_valid) req_reg <= req;
    end

    assign base = {lo_reg, q_reg} & pcam_pkg::IDE_BASE_MASK;

    // clearing pass walks slot by slot, offset by offset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            init_slot_reg <= pcam_pkg::SLOT_HOST;
            init_off_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_INIT) begin
                if (init_off_reg == AW'(SPACE_BYTES - 1)) begin
                    init_off_reg <= '0;
                    init_slot_reg <= init_slot_reg + 2'd1;
                end else begin
                    init_off_reg <= init_off_reg + 1'b1;
                end
            end
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign rdata = q_reg;

`ifndef NO_ASSERTIONS
    a_done_once: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !done) else $error("done twice");
    a_base_after_ide: assert property (@(posedge aclk) disable iff (!aresetn)
        base_valid |-> req_reg.slot == pcam_pkg::SLOT_IDE) else $error("base bad slot");
    a_req_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RMW) |-> $past(req_valid)) else $error("rmw without request");
`endif
endmodule
`default_nettype wire

>>> design/pci_config_access_with_write_masks.sv
// top level of pci configuration mechanism one with per-function write masks
`default_nettype none
// Byte access to the eight ports from 0xcf8. Offsets 0-3 reach the address
// register, 4-7 the data window into bus 0 configuration space of three
// functions (host bridge, isa bridge, ide). Each transfer gives exactly one
// result. For address register and rejected window accesses the result is
// valid in the cycle after acceptance and the next transfer can be taken at
// the same edge that drains it. A window access does one read-modify-write
// of the config memory, whose read data is registered, and a write to ide
// offset 0x23 goes on through the states ST_B21 and ST_B21W since the two
// i/o base bytes are read back through the same memory read port. After
// reset a clearing pass loads the default tables, during which no transfer
// is accepted. A result waits in an output register; the next input transfer
// is taken once the memory engine is free and the output register is empty
// or being drained.
module pci_config_access_with_write_masks #(
    parameter int SPACE_BYTES = pcam_pkg::SPACE_BYTES_DEF,
    parameter int SHADOW_SEGMENTS = pcam_pkg::SHADOW_SEGMENTS_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  pcam_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output pcam_pkg::out_item_t  m_data
);
    logic [31:0] addr_reg;
    logic [SHADOW_SEGMENTS-1:0] shadow_reg, shadow_next;
    logic [15:0] ann_reg;
    logic out_valid_reg, out_valid_next;
    pcam_pkg::out_item_t out_reg;
    logic pend_reg;          // window access in flight
    logic [7:0] pend_off_reg;
    logic [7:0] pend_data_reg;
    logic pend_wr_reg;
    logic pend_host_wr_reg;

    logic accept, busy, done, base_valid, remap_hit;
    logic [7:0] rdata;
    logic [15:0] base;
    logic [1:0] lane;
    logic [7:0] devfn, off;
    logic [1:0] slot;
    logic slot_ok, win_ok, is_win;
    pcam_pkg::mem_req_t req;
    logic [31:0] addr_new;

    // one transfer in flight at a time; output register must be free or draining
    assign s_ready = !busy && !pend_reg && (!out_valid_reg || m_ready) && !done;
    assign accept = s_valid && s_ready;

    assign lane = s_data.port_offset[1:0];
    assign is_win = s_data.port_offset[2];
    assign devfn = addr_reg[15:8];
    assign off = {addr_reg[7:2], lane};

    always_comb begin
        slot = pcam_pkg::SLOT_HOST;
        slot_ok = 1'b1;
        if (devfn == pcam_pkg::DEVFN_HOST) slot = pcam_pkg::SLOT_HOST;
        else if (devfn == pcam_pkg::DEVFN_ISA) slot = pcam_pkg::SLOT_ISA;
        else if (devfn == pcam_pkg::DEVFN_IDE) slot = pcam_pkg::SLOT_IDE;
        else slot_ok = 1'b0;
    end

    assign win_ok = addr_reg[31] && addr_reg[23:16] == 8'h00 && slot_ok &&
                    (32'(off) < SPACE_BYTES);

    assign req.is_write = s_data.func == pcam_pkg::FUNC_WRITE;
    assign req.slot = slot;
    assign req.off = off;
    assign req.data = s_data.write_data;

    pcam_store #(.SPACE_BYTES(SPACE_BYTES)) u_store (
        .aclk(aclk), .aresetn(aresetn),
        .req_valid(accept && is_win && win_ok), .req(req),
        .busy(busy), .done(done), .rdata(rdata),
        .base_valid(base_valid), .base(base)
    );

    always_comb begin
        addr_new = addr_reg;
        addr_new[8*lane +: 8] = s_data.write_data;
        addr_new = addr_new & ~pcam_pkg::ADDR_CLEAR_MASK;
    end

    // shadow enables from host offsets 0x59..0x5f
    always_comb begin
        shadow_next = shadow_reg;
        if (pend_host_wr_reg) begin
            if (pend_off_reg == 8'h59) begin
                shadow_next[15:12] = {4{pend_data_reg[5]}};
            end else if (pend_off_reg >= 8'h5A && pend_off_reg <= 8'h5F) begin
                shadow_next[4'(2 * (pend_off_reg - 8'h59) - 2)] = pend_data_reg[1];
                shadow_next[4'(2 * (pend_off_reg - 8'h59) - 1)] = pend_data_reg[5];
            end
        end
    end

    // event only when the base differs from the last one reported
    assign remap_hit = base_valid && base != ann_reg;

    // result register fills on a direct answer or a finished window access
    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        if ((accept && !(is_win && win_ok)) || done) out_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= '0;
            shadow_reg <= '0;
            ann_reg <= pcam_pkg::IDE_BASE_RESET;
            out_valid_reg <= 1'b0;
            pend_reg <= 1'b0;
            pend_wr_reg <= 1'b0;
            pend_host_wr_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                if (is_win && win_ok) begin
                    pend_reg <= 1'b1;
                    pend_off_reg <= off;
                    pend_data_reg <= s_data.write_data;
                    pend_wr_reg <= req.is_write;
                    pend_host_wr_reg <= req.is_write && slot == pcam_pkg::SLOT_HOST;
                end else begin
                    // address register or rejected window access answers directly
                    out_reg.shadow_write_enable <= 16'(shadow_reg);
                    out_reg.remap_valid <= 1'b0;
                    out_reg.remap_base <= '0;
                    if (!is_win) begin
                        if (req.is_write) addr_reg <= addr_new;
                        out_reg.read_data <= req.is_write ? 8'h00 : addr_reg[8*lane +: 8];
                    end else begin
                        out_reg.read_data <= req.is_write ? 8'h00 : 8'hFF;
                    end
                end
            end else if (done) begin
                pend_reg <= 1'b0;
                pend_host_wr_reg <= 1'b0;
                shadow_reg <= shadow_next;
                out_reg.shadow_write_enable <= 16'(shadow_next);
                out_reg.read_data <= pend_wr_reg ? 8'h00 : rdata;
                out_reg.remap_valid <= remap_hit;
                out_reg.remap_base <= remap_hit ? base : 16'h0000;
                if (remap_hit) ann_reg <= base;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

`ifndef NO_ASSERTIONS
    a_one_source: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> pend_reg) else $error("done without pending access");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !done) else $error("result overwritten");
    a_remap_base: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.remap_valid) |-> m_data.remap_base[3:0] == 4'h0)
        else $error("remap base low bits");
`endif
endmodule
`default_nettype wire
